FILE: hdl/bwa_pkg.sv
// Shared types, widths and operation codes for the byte/word ALU.
// No dependencies; imported by the channel interfaces and the top level.
package bwa_pkg;

    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int DIV_CNT_W = $clog2(DATA_W + 1);

    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [DIV_CNT_W-1:0] div_cnt_t;

    localparam kind_t OP_ADD = 3'd0;
    localparam kind_t OP_SUB = 3'd1;
    localparam kind_t OP_MUL = 3'd2;
    localparam kind_t OP_DIV = 3'd3;
    localparam kind_t OP_POW = 3'd4;

    localparam div_cnt_t DIV_STEPS = div_cnt_t'(DATA_W);

    // Operand/result mask for the selected width
    function automatic data_t width_mask(input logic word_mode);
        data_t m;
        m = word_mode ? {DATA_W{1'b1}} : data_t'({BYTE_W{1'b1}});
        return m;
    endfunction

endpackage

FILE: hdl/bwa_req_if.sv
// Request channel of the byte/word ALU: valid/ready plus operation payload.
// Depends on bwa_pkg.
interface bwa_req_if
    import bwa_pkg::*;
;
    logic  valid;
    logic  ready;
    kind_t kind;
    logic  word_mode;
    data_t operand_a;
    data_t operand_b;

    modport source (output valid, output kind, output word_mode,
                    output operand_a, output operand_b, input ready);
    modport sink   (input valid, input kind, input word_mode,
                    input operand_a, input operand_b, output ready);
endinterface

FILE: hdl/bwa_rsp_if.sv
// Result channel of the byte/word ALU: valid/ready plus result payload.
// Depends on bwa_pkg.
interface bwa_rsp_if
    import bwa_pkg::*;
;
    logic  valid;
    logic  ready;
    data_t result_value;
    logic  divide_by_zero;

    modport source (output valid, output result_value, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input result_value, input divide_by_zero,
                    output ready);
endinterface

FILE: hdl/byte_word_alu_with_power.sv
// Unsigned 8/16-bit ALU (add, subtract, multiply, divide, power), one request
// at a time. A request is taken only while the sequencer is idle; the result
// sits in an output register so the next request can be taken while it waits.
// From acceptance to result: add, subtract, multiply, unused codes and
// divide by zero finish directly; divide takes one restoring step of its own
// subtractor per quotient bit; power squares once per exponent bit below the
// top set bit and multiplies into the accumulator once per set bit, all on
// the single shared 16x16 multiplier, and finishes with the accumulator once
// the remaining exponent is zero. The sequencer returns to idle when the result is registered.
// Depends on bwa_pkg, bwa_req_if and bwa_rsp_if.
module byte_word_alu_with_power
    import bwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bwa_req_if.sink    req,
    bwa_rsp_if.source  rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;
    kind_t      kind_reg, kind_next;
    logic       word_reg, word_next;
    data_t      acc_reg, acc_next;    // power accumulator / dividend-quotient
    data_t      aux_reg, aux_next;    // power square / partial remainder
    data_t      opb_reg, opb_next;    // divisor / remaining exponent
    div_cnt_t   cnt_reg, cnt_next;
    logic       dz_reg, dz_next;

    logic       out_valid_reg, out_valid_next;
    data_t      out_value_reg, out_value_next;
    logic       out_dz_reg, out_dz_next;

    data_t                 mask_in, mask_run;
    data_t                 a_in, b_in;
    data_t                 mul_x, mul_y, prod_lo;
    logic [2*DATA_W-1:0]   product;
    logic [DATA_W:0]       trial;
    logic                  q_bit;
    data_t                 quo_shift;
    logic                  fin, fin_dz, out_free;
    data_t                 fin_value;

    assign mask_in  = width_mask(req.word_mode);
    assign mask_run = width_mask(word_reg);
    assign a_in     = req.operand_a & mask_in;
    assign b_in     = req.operand_b & mask_in;

    // Shared multiplier: square or multiply step of power, or plain multiply
    always_comb
    begin
        mul_x = acc_reg;
        mul_y = opb_reg;
        if (kind_reg == OP_POW)
        begin
            mul_x = opb_reg[0] ? acc_reg : aux_reg;
            mul_y = aux_reg;
        end
    end

    assign product = mul_x * mul_y;
    assign prod_lo = product[DATA_W-1:0];

    // Restoring division step on the division subtractor
    assign trial     = {aux_reg, acc_reg[DATA_W-1]} - {1'b0, opb_reg};
    assign q_bit     = ~trial[DATA_W];
    assign quo_shift = {acc_reg[DATA_W-2:0], q_bit};

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        word_next      = word_reg;
        acc_next       = acc_reg;
        aux_next       = aux_reg;
        opb_next       = opb_reg;
        cnt_next       = cnt_reg;
        dz_next        = dz_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_dz_next    = out_dz_reg;
        fin            = 1'b0;
        fin_value      = '0;
        fin_dz         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next = req.kind;
                    word_next = req.word_mode;
                    opb_next  = b_in;
                    cnt_next  = DIV_STEPS;
                    dz_next   = 1'b0;
                    if (req.kind == OP_POW)
                    begin
                        acc_next = data_t'(1);
                        aux_next = a_in;
                    end
                    else
                    begin
                        acc_next = a_in;
                        aux_next = '0;
                    end
                    state_next = S_RUN;
                end
            end

            S_RUN:
            begin
                case (kind_reg)
                    OP_ADD:
                    begin
                        fin       = 1'b1;
                        fin_value = acc_reg + opb_reg;
                    end
                    OP_SUB:
                    begin
                        fin       = 1'b1;
                        fin_value = acc_reg - opb_reg;
                    end
                    OP_MUL:
                    begin
                        fin       = 1'b1;
                        fin_value = prod_lo;
                    end
                    OP_DIV:
                    begin
                        if (opb_reg == '0)
                        begin
                            fin    = 1'b1;
                            fin_dz = 1'b1;
                        end
                        else
                        begin
                            acc_next = quo_shift;
                            aux_next = q_bit ? trial[DATA_W-1:0]
                                             : {aux_reg[DATA_W-2:0], acc_reg[DATA_W-1]};
                            cnt_next = cnt_reg - div_cnt_t'(1);
                            if (cnt_reg == div_cnt_t'(1))
                            begin
                                fin       = 1'b1;
                                fin_value = quo_shift;
                            end
                        end
                    end
                    OP_POW:
                    begin
                        // set bit: fold square into accumulator, then clear it;
                        // clear bit: square and move to the next exponent bit
                        if (opb_reg == '0)
                        begin
                            fin       = 1'b1;
                            fin_value = acc_reg;
                        end
                        else if (opb_reg[0])
                        begin
                            acc_next = prod_lo & mask_run;
                            opb_next = {opb_reg[DATA_W-1:1], 1'b0};
                        end
                        else
                        begin
                            aux_next = prod_lo & mask_run;
                            opb_next = opb_reg >> 1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase

                if (fin)
                begin
                    acc_next = fin_value & mask_run;
                    dz_next  = fin_dz;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = fin_value & mask_run;
                        out_dz_next    = fin_dz;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end

            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = acc_reg;
                    out_dz_next    = dz_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        word_reg      <= word_next;
        acc_reg       <= acc_next;
        aux_reg       <= aux_next;
        opb_reg       <= opb_next;
        cnt_reg       <= cnt_next;
        dz_reg        <= dz_next;
        out_value_reg <= out_value_next;
        out_dz_reg    <= out_dz_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_value   = out_value_reg;
    assign rsp.divide_by_zero = out_dz_reg;

    // a taken request always leaves the sequencer busy in the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("sequencer still idle after taking a request");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.divide_by_zero |-> rsp.result_value == '0)
        else $error("divide-by-zero result is not zero");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN && kind_reg == OP_DIV |-> cnt_reg != '0)
        else $error("division step count ran out while still running");

    a_new_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !$past(rsp.valid) |->
            $past(state_reg) == S_RUN || $past(state_reg) == S_HOLD)
        else $error("result appeared without a finishing sequencer");

endmodule
